FILE: hw/rtl/rvad_pkg.sv
// ----------------------------------------------------------------------------
// rvad_pkg
// Shared types, codes and constants of the RMS voice activity detector.
// ----------------------------------------------------------------------------
package rvad_pkg;

  localparam int FRAME_MAX_DEF = 1024;
  localparam int RMS_W         = 24;
  localparam int SQ_W          = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int TS_W          = 32;
  localparam int THR_W         = 16;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_STOP   = 2'd2;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_LISTEN  = 2'd1;
  localparam logic [1:0] MODE_RECORD  = 2'd2;
  localparam logic [1:0] MODE_SILENCE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REC     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LISTEN_TO   = 3'd5;

  localparam logic [THR_W-1:0] SPEECH_THR_RST  = 16'd1000;
  localparam logic [THR_W-1:0] SILENCE_THR_RST = 16'd500;
  localparam logic [TS_W-1:0]  MIN_SPEECH_RST  = 32'd200;
  localparam logic [TS_W-1:0]  SILENCE_TO_RST  = 32'd1500;
  localparam logic [TS_W-1:0]  MAX_REC_RST     = 32'd15000;
  localparam logic [TS_W-1:0]  LISTEN_TO_RST   = 32'd10000;

  typedef struct packed {
    logic [TS_W-1:0] min_speech;
    logic [TS_W-1:0] silence_to;
    logic [TS_W-1:0] max_rec;
    logic [TS_W-1:0] listen_to;
  } sess_cfg_t;

  typedef struct packed {
    logic            start;
    logic            stop;
    logic            eval;
    logic            voice;
    logic            quiet;
    logic [TS_W-1:0] now;
  } sess_ctrl_t;

endpackage

FILE: hw/rtl/rvad_if.sv
// ----------------------------------------------------------------------------
// rvad_if
// Channel interfaces: sample/command input, result output, register writes.
// ----------------------------------------------------------------------------
interface rvad_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic signed [15:0]             sample;
  logic                           last_in_frame;
  logic [rvad_pkg::TS_W-1:0]      now_ms;

  modport source (output valid, action, sample, last_in_frame, now_ms, input ready);
  modport sink   (input valid, action, sample, last_in_frame, now_ms, output ready);
endinterface

interface rvad_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     vad_state;
  logic [rvad_pkg::RMS_W-1:0]     frame_rms;
  logic [rvad_pkg::RMS_W-1:0]     smoothed_rms;

  modport source (output valid, vad_state, frame_rms, smoothed_rms, input ready);
  modport sink   (input valid, vad_state, frame_rms, smoothed_rms, output ready);
endinterface

interface rvad_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rvad_pkg::CFG_IDX_W-1:0]    index;
  logic [rvad_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rvad_sub.sv
// ----------------------------------------------------------------------------
// rvad_sub
// Shared compare-and-subtract unit for the divide and square-root steps.
// ----------------------------------------------------------------------------
module rvad_sub #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[W-1:0];
  assign ge   = ~wide[W];

endmodule

FILE: hw/rtl/rvad_rms_unit.sv
// ----------------------------------------------------------------------------
// rvad_rms_unit
// Frame RMS: restoring divide of sum*65536 by count, then a bit-pair integer
// square root, both one step a cycle through the shared subtract unit.
// ----------------------------------------------------------------------------
module rvad_rms_unit #(
  parameter int SUM_W = 41,
  parameter int CNT_W = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SUM_W-1:0]           sum,
  input  logic [CNT_W-1:0]           cnt,
  output logic                       done,
  output logic [rvad_pkg::RMS_W-1:0] rms
);

  localparam int DVD_W  = SUM_W + 16;
  localparam int RT_W   = (DVD_W + 1) / 2;
  localparam int PAIR_W = 2 * RT_W;
  localparam int DREM_W = CNT_W + 1;
  localparam int SREM_W = RT_W + 2;
  localparam int ALU_W  = (DREM_W > SREM_W) ? DREM_W : SREM_W;
  localparam int STEP_W = $clog2(DVD_W);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_DIV  = 2'd1;
  localparam logic [1:0] U_SQRT = 2'd2;
  localparam logic [1:0] U_DONE = 2'd3;

  logic [1:0]        state_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  drem_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [PAIR_W-1:0] sq_r;
  logic [SREM_W-1:0] srem_r;
  logic [RT_W-1:0]   root_r;
  logic              zero_r;

  logic [DREM_W-1:0] div_a;
  logic [SREM_W-1:0] sq_a;
  logic [SREM_W-1:0] sq_b;
  logic [ALU_W-1:0]  alu_a;
  logic [ALU_W-1:0]  alu_b;
  logic [ALU_W-1:0]  alu_diff;
  logic              alu_ge;

  assign div_a = {drem_r, dvd_r[DVD_W-1]};
  assign sq_a  = {srem_r[RT_W-1:0], sq_r[PAIR_W-1 -: 2]};
  assign sq_b  = {root_r, 2'b01};

  always_comb begin
    if (state_r == U_DIV) begin
      alu_a = ALU_W'(div_a);
      alu_b = ALU_W'(dsr_r);
    end else begin
      alu_a = ALU_W'(sq_a);
      alu_b = ALU_W'(sq_b);
    end
  end

  rvad_sub #(.W(ALU_W)) u_sub (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        U_IDLE: begin
          if (start) begin
            state_r <= U_DIV;
            step_r  <= '0;
          end
        end
        U_DIV: begin
          if (step_r == STEP_W'(DVD_W - 1)) begin
            state_r <= U_SQRT;
            step_r  <= '0;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        U_SQRT: begin
          if (step_r == STEP_W'(RT_W - 1)) begin
            state_r <= U_DONE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        U_DONE: begin
          state_r <= U_IDLE;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      U_IDLE: begin
        if (start) begin
          dvd_r  <= {sum, 16'h0000};
          drem_r <= '0;
          dsr_r  <= cnt;
          zero_r <= (cnt == '0);
        end
      end
      U_DIV: begin
        dvd_r  <= {dvd_r[DVD_W-2:0], alu_ge};
        drem_r <= alu_ge ? alu_diff[CNT_W-1:0] : div_a[CNT_W-1:0];
        if (step_r == STEP_W'(DVD_W - 1)) begin
          sq_r   <= PAIR_W'({dvd_r[DVD_W-2:0], alu_ge});
          srem_r <= '0;
          root_r <= '0;
        end
      end
      U_SQRT: begin
        sq_r   <= {sq_r[PAIR_W-3:0], 2'b00};
        srem_r <= alu_ge ? alu_diff[SREM_W-1:0] : sq_a;
        root_r <= {root_r[RT_W-2:0], alu_ge};
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == U_DONE);
  assign rms  = zero_r ? '0 : root_r[rvad_pkg::RMS_W-1:0];

endmodule

FILE: hw/rtl/rvad_session.sv
// ----------------------------------------------------------------------------
// rvad_session
// Session state: mode, time stamps and onset flag, updated on commands and
// at each evaluated frame end.
// ----------------------------------------------------------------------------
module rvad_session (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rvad_pkg::sess_ctrl_t  ctrl,
  input  rvad_pkg::sess_cfg_t   cfg,
  output logic [1:0]            mode
);

  localparam int TW = rvad_pkg::TS_W;

  logic [1:0]    mode_r,   mode_nxt;
  logic [TW-1:0] listen_r, listen_nxt;
  logic [TW-1:0] onset_r,  onset_nxt;
  logic [TW-1:0] vseen_r,  vseen_nxt;
  logic [TW-1:0] rec_r,    rec_nxt;
  logic          conf_r,   conf_nxt;

  logic [TW-1:0] d_onset;
  logic [TW-1:0] d_listen;
  logic [TW-1:0] d_vseen;
  logic [TW-1:0] d_rec;

  assign d_onset  = ctrl.now - onset_r;
  assign d_listen = ctrl.now - listen_r;
  assign d_rec    = ctrl.now - rec_r;

  always_comb begin
    mode_nxt   = mode_r;
    listen_nxt = listen_r;
    onset_nxt  = onset_r;
    vseen_nxt  = vseen_r;
    rec_nxt    = rec_r;
    conf_nxt   = conf_r;
    d_vseen    = ctrl.now - vseen_r;
    priority if (ctrl.start) begin
      mode_nxt   = rvad_pkg::MODE_LISTEN;
      listen_nxt = ctrl.now;
      onset_nxt  = '0;
      vseen_nxt  = '0;
      rec_nxt    = '0;
      conf_nxt   = 1'b0;
    end else if (ctrl.stop) begin
      mode_nxt = rvad_pkg::MODE_IDLE;
    end else if (ctrl.eval) begin
      if (mode_r == rvad_pkg::MODE_LISTEN) begin
        if (ctrl.voice) begin
          if (onset_r == '0) begin
            onset_nxt = ctrl.now;
          end else if (d_onset >= cfg.min_speech) begin
            mode_nxt  = rvad_pkg::MODE_RECORD;
            rec_nxt   = onset_r;
            vseen_nxt = ctrl.now;
            conf_nxt  = 1'b1;
          end
        end else begin
          onset_nxt = '0;
        end
        if (!conf_nxt && (d_listen > cfg.listen_to)) begin
          mode_nxt = rvad_pkg::MODE_SILENCE;
        end
      end else if (mode_r == rvad_pkg::MODE_RECORD) begin
        if (ctrl.voice) begin
          vseen_nxt = ctrl.now;
        end
        d_vseen = ctrl.now - vseen_nxt;
        if (ctrl.quiet && (vseen_nxt != '0) && (d_vseen >= cfg.silence_to)) begin
          mode_nxt = rvad_pkg::MODE_SILENCE;
        end else if ((rec_r != '0) && (d_rec >= cfg.max_rec)) begin
          mode_nxt = rvad_pkg::MODE_SILENCE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= rvad_pkg::MODE_IDLE;
      listen_r <= '0;
      onset_r  <= '0;
      vseen_r  <= '0;
      rec_r    <= '0;
      conf_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      listen_r <= listen_nxt;
      onset_r  <= onset_nxt;
      vseen_r  <= vseen_nxt;
      rec_r    <= rec_nxt;
      conf_r   <= conf_nxt;
    end
  end

  assign mode = mode_r;

endmodule

FILE: hw/rtl/rms_voice_activity_detector_core.sv
// ----------------------------------------------------------------------------
// rms_voice_activity_detector_core
// Energy-based voice activity detector: squares and sums samples per frame,
// computes frame and smoothed RMS in Q16.8 and runs the session state.
// ----------------------------------------------------------------------------
// Sample path: a sample that does not end a frame is accepted, then added.
// Start, stop and a frame end while idle (via S_ACC) go to S_EMIT, which
// loads the result once the output register is free. Active frame end:
// (SUM_W+16) divide, (SUM_W+17)/2 root steps, then S_SMOOTH, S_EVAL, S_EMIT.
// One transaction in flight; a waiting result does not block input.
// Reset: synchronous, active low; clears control and session state, loads the
// register defaults.
module rms_voice_activity_detector_core #(
  parameter int FRAME_MAX = rvad_pkg::FRAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rvad_in_if.sink     in_ch,
  rvad_out_if.source  out_ch,
  rvad_cfg_if.sink    cfg_ch
);

  localparam int CNT_W = $clog2(FRAME_MAX + 1);
  localparam int SUM_W = rvad_pkg::SQ_W + $clog2(FRAME_MAX);
  localparam int RW    = rvad_pkg::RMS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACC    = 3'd1;
  localparam logic [2:0] S_KICK   = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_SMOOTH = 3'd4;
  localparam logic [2:0] S_EVAL   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]                  state_r;
  logic [rvad_pkg::THR_W-1:0]  speech_thr_r;
  logic [rvad_pkg::THR_W-1:0]  silence_thr_r;
  rvad_pkg::sess_cfg_t         tcfg_r;

  logic [rvad_pkg::SQ_W-1:0]   sq_r;
  logic                        acc_en_r;
  logic                        last_r;
  logic [rvad_pkg::TS_W-1:0]   now_r;
  logic [SUM_W-1:0]            sum_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [RW-1:0]               rms_now_r;
  logic [RW-1:0]               rms_smooth_r;

  logic                        out_valid_r;
  logic [1:0]                  out_state_r;
  logic [RW-1:0]               out_frame_r;
  logic [RW-1:0]               out_smooth_r;

  logic                        in_acc;
  logic                        out_free;
  logic [15:0]                 raw;
  logic [15:0]                 mag;
  logic [RW+1:0]               smooth_sum;
  logic [1:0]                  mode;
  logic                        rms_start;
  logic                        rms_done;
  logic [RW-1:0]               rms_val;
  rvad_pkg::sess_ctrl_t        sctrl;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign raw        = $unsigned(in_ch.sample);
  assign mag        = raw[15] ? (~raw + 16'd1) : raw;
  assign smooth_sum = {1'b0, rms_smooth_r, 1'b0} + {2'b00, rms_smooth_r} +
                      {2'b00, rms_now_r};
  assign rms_start  = (state_r == S_KICK);

  always_comb begin
    sctrl.start = in_acc && (in_ch.action == rvad_pkg::ACT_START);
    sctrl.stop  = in_acc && (in_ch.action == rvad_pkg::ACT_STOP);
    sctrl.eval  = (state_r == S_EVAL);
    sctrl.voice = rms_smooth_r >= {speech_thr_r, 8'h00};
    sctrl.quiet = rms_smooth_r <= {silence_thr_r, 8'h00};
    sctrl.now   = (state_r == S_EVAL) ? now_r : in_ch.now_ms;
  end

  rvad_session u_session (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (sctrl),
    .cfg   (tcfg_r),
    .mode  (mode)
  );

  rvad_rms_unit #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_rms (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rms_start),
    .sum   (sum_r),
    .cnt   (cnt_r),
    .done  (rms_done),
    .rms   (rms_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speech_thr_r      <= rvad_pkg::SPEECH_THR_RST;
      silence_thr_r     <= rvad_pkg::SILENCE_THR_RST;
      tcfg_r.min_speech <= rvad_pkg::MIN_SPEECH_RST;
      tcfg_r.silence_to <= rvad_pkg::SILENCE_TO_RST;
      tcfg_r.max_rec    <= rvad_pkg::MAX_REC_RST;
      tcfg_r.listen_to  <= rvad_pkg::LISTEN_TO_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        rvad_pkg::REG_SPEECH_THR:  speech_thr_r      <= cfg_ch.data[rvad_pkg::THR_W-1:0];
        rvad_pkg::REG_SILENCE_THR: silence_thr_r     <= cfg_ch.data[rvad_pkg::THR_W-1:0];
        rvad_pkg::REG_MIN_SPEECH:  tcfg_r.min_speech <= cfg_ch.data;
        rvad_pkg::REG_SILENCE_TO:  tcfg_r.silence_to <= cfg_ch.data;
        rvad_pkg::REG_MAX_REC:     tcfg_r.max_rec    <= cfg_ch.data;
        rvad_pkg::REG_LISTEN_TO:   tcfg_r.listen_to  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sum_r        <= '0;
      cnt_r        <= '0;
      rms_now_r    <= '0;
      rms_smooth_r <= '0;
      acc_en_r     <= 1'b0;
      last_r       <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_ch.action)
              rvad_pkg::ACT_START: begin
                rms_now_r    <= '0;
                rms_smooth_r <= '0;
                sum_r        <= '0;
                cnt_r        <= '0;
                state_r      <= S_EMIT;
              end
              rvad_pkg::ACT_STOP: begin
                sum_r   <= '0;
                cnt_r   <= '0;
                state_r <= S_EMIT;
              end
              rvad_pkg::ACT_SAMPLE: begin
                acc_en_r <= (mode != rvad_pkg::MODE_IDLE) && (cnt_r < CNT_W'(FRAME_MAX));
                last_r   <= in_ch.last_in_frame;
                state_r  <= S_ACC;
              end
              default: begin
              end
            endcase
          end
        end
        S_ACC: begin
          priority if (last_r && (mode == rvad_pkg::MODE_IDLE)) begin
            sum_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            if (acc_en_r) begin
              sum_r <= sum_r + SUM_W'(sq_r);
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= last_r ? S_KICK : S_IDLE;
          end
        end
        S_KICK: begin
          sum_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (rms_done) begin
            rms_now_r <= rms_val;
            state_r   <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          rms_smooth_r <= smooth_sum[RW+1:2];
          state_r      <= S_EVAL;
        end
        S_EVAL: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.action == rvad_pkg::ACT_SAMPLE)) begin
      sq_r  <= rvad_pkg::SQ_W'(mag) * rvad_pkg::SQ_W'(mag);
      now_r <= in_ch.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && out_free) begin
      out_state_r  <= mode;
      out_frame_r  <= rms_now_r;
      out_smooth_r <= rms_smooth_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vad_state    = out_state_r;
  assign out_ch.frame_rms    = out_frame_r;
  assign out_ch.smoothed_rms = out_smooth_r;

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rms_done |-> (state_r == S_RUN))
    else $error("rms unit finished outside of the wait state");

  a_record_by_eval: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode == rvad_pkg::MODE_RECORD) && ($past(mode) != rvad_pkg::MODE_RECORD))
    |-> $past(state_r == S_EVAL))
    else $error("recording entered without a frame evaluation");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KICK) |=> ((sum_r == '0) && (cnt_r == '0)))
    else $error("frame accumulator not cleared after frame end");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result not loaded into the output register");

endmodule
